// ===== rtl/mtc_enc_pkg.sv =====
package mtc_enc_pkg;

  localparam int unsigned MTC_FPS_DEFAULT = 30;

  // reciprocal constants for division by multiplication
  localparam int unsigned DIV1000_SHIFT = 38;
  localparam logic [28:0] RECIP_1000 = 29'(((64'd1 << DIV1000_SHIFT) + 64'd999) / 64'd1000);
  localparam int unsigned DIV60_SHIFT = 26;
  localparam logic [20:0] RECIP_60 = 21'(((64'd1 << DIV60_SHIFT) + 64'd59) / 64'd60);
  localparam int unsigned DIVFPS_SHIFT = 32;

  localparam logic [1:0] RATE_CODE = 2'd3;

  typedef enum logic [1:0] {
    CMD_QUARTER = 2'd0,
    CMD_FULL    = 2'd1,
    CMD_START   = 2'd2,
    CMD_STOP    = 2'd3
  } mtc_cmd_t;

  localparam logic [3:0] CIN_QUARTER  = 4'h2;
  localparam logic [3:0] CIN_SYSEX    = 4'h4;
  localparam logic [3:0] CIN_SYSEX_E1 = 4'h5;
  localparam logic [3:0] CIN_REALTIME = 4'hF;

  localparam logic [7:0] ST_QUARTER = 8'hF1;
  localparam logic [7:0] ST_SYSEX   = 8'hF0;
  localparam logic [7:0] ST_UNIV_RT = 8'h7F;
  localparam logic [7:0] ST_EOX     = 8'hF7;
  localparam logic [7:0] ST_START   = 8'hFA;
  localparam logic [7:0] ST_STOP    = 8'hFC;
  localparam logic [7:0] SX_MTC     = 8'h01;
  localparam logic [7:0] SX_FULL    = 8'h01;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [4:0] frames;
  } mtc_time_t;

  typedef struct packed {
    mtc_cmd_t  cmd;
    mtc_time_t tc;
  } mtc_item_t;

  typedef struct packed {
    logic [3:0] cable_header;
    logic [7:0] status_byte;
    logic [7:0] data_one;
    logic [7:0] data_two;
    logic       last;
  } mtc_pkt_t;

  function automatic mtc_pkt_t mtc_packet(mtc_cmd_t cmd, logic [2:0] idx, mtc_time_t tc);
    mtc_pkt_t   p;
    logic [3:0] nib;
    p   = '0;
    nib = '0;
    unique case (cmd)
      CMD_QUARTER: begin
        case (idx)
          3'd0:    nib = tc.frames[3:0];
          3'd1:    nib = {3'b000, tc.frames[4]};
          3'd2:    nib = tc.seconds[3:0];
          3'd3:    nib = {2'b00, tc.seconds[5:4]};
          3'd4:    nib = tc.minutes[3:0];
          3'd5:    nib = {2'b00, tc.minutes[5:4]};
          3'd6:    nib = tc.hours[3:0];
          default: nib = {1'b0, RATE_CODE, tc.hours[4]};
        endcase
        p.cable_header = CIN_QUARTER;
        p.status_byte  = ST_QUARTER;
        p.data_one     = {1'b0, idx, nib};
        p.data_two     = '0;
        p.last         = (idx == 3'd7);
      end
      CMD_FULL: begin
        case (idx)
          3'd0: begin
            p.cable_header = CIN_SYSEX;
            p.status_byte  = ST_SYSEX;
            p.data_one     = ST_UNIV_RT;
            p.data_two     = ST_UNIV_RT;
          end
          3'd1: begin
            p.cable_header = CIN_SYSEX;
            p.status_byte  = SX_MTC;
            p.data_one     = SX_FULL;
            p.data_two     = {1'b0, RATE_CODE, tc.hours};
          end
          3'd2: begin
            p.cable_header = CIN_SYSEX;
            p.status_byte  = {2'b00, tc.minutes};
            p.data_one     = {2'b00, tc.seconds};
            p.data_two     = {3'b000, tc.frames};
          end
          default: begin
            p.cable_header = CIN_SYSEX_E1;
            p.status_byte  = ST_EOX;
            p.last         = 1'b1;
          end
        endcase
      end
      CMD_START: begin
        p.cable_header = CIN_REALTIME;
        p.status_byte  = ST_START;
        p.last         = 1'b1;
      end
      default: begin
        p.cable_header = CIN_REALTIME;
        p.status_byte  = ST_STOP;
        p.last         = 1'b1;
      end
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/mtc_enc_time_split.sv =====
module mtc_enc_time_split
  import mtc_enc_pkg::*;
#(
  parameter int unsigned FRAMES_PER_SECOND = MTC_FPS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  mtc_cmd_t    in_cmd,
  input  logic [31:0] in_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output mtc_item_t   out_item
);

  localparam logic [31:0] FPS_32    = 32'(FRAMES_PER_SECOND);
  localparam logic [4:0]  FPS_5     = 5'(FRAMES_PER_SECOND);
  localparam logic [27:0] RECIP_FPS =
    28'(((64'd1 << DIVFPS_SHIFT) + 64'(FRAMES_PER_SECOND) - 64'd1) / 64'(FRAMES_PER_SECOND));
  localparam logic [5:0]  SIXTY     = 6'd60;

  logic [5:0] v_r;
  logic [5:0] en;

  always_comb begin
    en[5] = !v_r[5] || out_ready;
    for (int i = 4; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < 6; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // stage 1: ms times frame rate, wrapped to 32 bits
  mtc_cmd_t    s1_cmd_r;
  logic [31:0] s1_prod_r;
  logic [31:0] s1_prod_nxt;
  assign s1_prod_nxt = in_ms * FPS_32;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_cmd_r  <= in_cmd;
      s1_prod_r <= s1_prod_nxt;
    end
  end

  // stage 2: total frames = product / 1000
  mtc_cmd_t    s2_cmd_r;
  logic [22:0] s2_total_r;
  logic [60:0] s2_mul;
  assign s2_mul = 61'(s1_prod_r) * 61'(RECIP_1000);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_cmd_r   <= s1_cmd_r;
      s2_total_r <= s2_mul[DIV1000_SHIFT +: 23];
    end
  end

  // stage 3: whole seconds = total / fps
  mtc_cmd_t    s3_cmd_r;
  logic [22:0] s3_total_r;
  logic [18:0] s3_sec_r;
  logic [50:0] s3_mul;
  assign s3_mul = 51'(s2_total_r) * 51'(RECIP_FPS);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_cmd_r   <= s2_cmd_r;
      s3_total_r <= s2_total_r;
      s3_sec_r   <= s3_mul[DIVFPS_SHIFT +: 19];
    end
  end

  // stage 4: frames remainder, whole minutes
  mtc_cmd_t    s4_cmd_r;
  logic [4:0]  s4_ff_r;
  logic [18:0] s4_sec_r;
  logic [11:0] s4_min_r;
  logic [22:0] s4_fmul;
  logic [22:0] s4_fdiff;
  logic [39:0] s4_mul;
  assign s4_fmul  = 23'(s3_sec_r) * 23'(FPS_5);
  assign s4_fdiff = s3_total_r - s4_fmul;
  assign s4_mul   = 40'(s3_sec_r) * 40'(RECIP_60);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_cmd_r <= s3_cmd_r;
      s4_ff_r  <= s4_fdiff[4:0];
      s4_sec_r <= s3_sec_r;
      s4_min_r <= s4_mul[DIV60_SHIFT +: 12];
    end
  end

  // stage 5: seconds remainder, whole hours
  mtc_cmd_t    s5_cmd_r;
  logic [4:0]  s5_ff_r;
  logic [5:0]  s5_ss_r;
  logic [11:0] s5_min_r;
  logic [5:0]  s5_hr_r;
  logic [18:0] s5_smul;
  logic [18:0] s5_sdiff;
  logic [32:0] s5_mul;
  assign s5_smul  = 19'(s4_min_r) * 19'(SIXTY);
  assign s5_sdiff = s4_sec_r - s5_smul;
  assign s5_mul   = 33'(s4_min_r) * 33'(RECIP_60);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_cmd_r <= s4_cmd_r;
      s5_ff_r  <= s4_ff_r;
      s5_ss_r  <= s5_sdiff[5:0];
      s5_min_r <= s4_min_r;
      s5_hr_r  <= s5_mul[DIV60_SHIFT +: 6];
    end
  end

  // stage 6: minutes remainder, hours modulo 24
  mtc_item_t   s6_item_r;
  logic [11:0] s6_mmul;
  logic [11:0] s6_mdiff;
  logic [5:0]  s6_hh;
  assign s6_mmul  = 12'(s5_hr_r) * 12'(SIXTY);
  assign s6_mdiff = s5_min_r - s6_mmul;

  always_comb begin
    if (s5_hr_r >= 6'd48) begin
      s6_hh = s5_hr_r - 6'd48;
    end else if (s5_hr_r >= 6'd24) begin
      s6_hh = s5_hr_r - 6'd24;
    end else begin
      s6_hh = s5_hr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_item_r.cmd        <= s5_cmd_r;
      s6_item_r.tc.frames  <= s5_ff_r;
      s6_item_r.tc.seconds <= s5_ss_r;
      s6_item_r.tc.minutes <= s6_mdiff[5:0];
      s6_item_r.tc.hours   <= s6_hh[4:0];
    end
  end

  assign out_valid = v_r[5];
  assign out_item  = s6_item_r;

endmodule

// ===== rtl/mtc_enc_packet_seq.sv =====
module mtc_enc_packet_seq
  import mtc_enc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  mtc_item_t in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output mtc_pkt_t  out_pkt
);

  logic       busy_r;
  mtc_item_t  item_r;
  logic [2:0] idx_r;
  logic       out_valid_r;
  mtc_pkt_t   out_pkt_r;
  mtc_pkt_t   pkt;
  logic       fire;
  logic       take;

  assign pkt      = mtc_packet(item_r.cmd, idx_r, item_r.tc);
  assign fire     = busy_r && (!out_valid_r || !out_stall);
  assign in_ready = !busy_r || (fire && pkt.last);
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (fire) begin
        idx_r <= idx_r + 3'd1;
        if (pkt.last) busy_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_pkt_r <= pkt;
    if (take) item_r <= in_item;
  end

  assign out_valid = out_valid_r;
  assign out_pkt   = out_pkt_r;

endmodule

// ===== rtl/midi_timecode_packet_encoder_core.sv =====
// the first packet passes the six split stages, then item_r and out_pkt_r
// throughput: one packet per cycle unless stalled; an item gives 8, 4
// or 1 packets (quarter frame, full frame, start or stop), set by u_seq
// the six-stage time split takes a new item each cycle unless it is held
// reset (synchronous, active low) clears all valid bits
module midi_timecode_packet_encoder_core
  import mtc_enc_pkg::*;
#(
  parameter int unsigned FRAMES_PER_SECOND = MTC_FPS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_position_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_cable_header,
  output logic [7:0]  out_status_byte,
  output logic [7:0]  out_data_one,
  output logic [7:0]  out_data_two,
  output logic        out_last
);

  logic      split_ready;
  logic      mid_valid;
  logic      mid_ready;
  mtc_item_t mid_item;
  mtc_pkt_t  pkt;

  mtc_enc_time_split #(
    .FRAMES_PER_SECOND(FRAMES_PER_SECOND)
  ) u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (split_ready),
    .in_cmd   (mtc_cmd_t'(in_command)),
    .in_ms    (in_position_ms),
    .out_valid(mid_valid),
    .out_ready(mid_ready),
    .out_item (mid_item)
  );

  mtc_enc_packet_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (mid_valid),
    .in_ready (mid_ready),
    .in_item  (mid_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pkt  (pkt)
  );

  assign in_stall         = !split_ready;
  assign out_cable_header = pkt.cable_header;
  assign out_status_byte  = pkt.status_byte;
  assign out_data_one     = pkt.data_one;
  assign out_data_two     = pkt.data_two;
  assign out_last         = pkt.last;

endmodule

// ===== rtl/mtc_enc_checker.sv =====
module mtc_enc_checker
  import mtc_enc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_cable_header,
  input logic [7:0]  out_status_byte,
  input logic [7:0]  out_data_one,
  input logic [7:0]  out_data_two,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status_byte)
      && $stable(out_data_one) && $stable(out_last))
    else $error("stalled result transfer changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_quarter_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cable_header == CIN_QUARTER |->
      out_status_byte == ST_QUARTER && out_data_two == 8'h00
      && out_last == (out_data_one[6:4] == 3'd7))
    else $error("bad quarter frame packet");

  a_realtime_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cable_header == CIN_REALTIME |->
      out_last && out_data_one == 8'h00 && out_data_two == 8'h00
      && (out_status_byte == ST_START || out_status_byte == ST_STOP))
    else $error("bad real-time packet");

  a_sysex_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_cable_header == CIN_SYSEX || out_cable_header == CIN_SYSEX_E1) |->
      out_last == (out_cable_header == CIN_SYSEX_E1))
    else $error("sysex end flag mismatch");

endmodule

bind midi_timecode_packet_encoder_core mtc_enc_checker u_mtc_enc_checker (.*);

// ===== tb/sv/mtc_packet_checker.sv =====
`timescale 1ns / 100ps

module mtc_packet_checker
  import mtc_enc_pkg::*;
#(
  parameter int unsigned FRAMES_PER_SECOND = MTC_FPS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_position_ms,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_cable_header,
  input  logic [7:0]  out_status_byte,
  input  logic [7:0]  out_data_one,
  input  logic [7:0]  out_data_two,
  input  logic        out_last,
  output int          mismatches,
  output int          packets_waiting,
  output int          packets_checked
);

  mtc_pkt_t packets_due[$];
  mtc_pkt_t want;
  mtc_pkt_t got;
  int       fails = 0;
  int       checked = 0;

  function automatic void queue_packet(logic [3:0] hdr, logic [7:0] st, logic [7:0] d1,
                                       logic [7:0] d2, logic last);
    mtc_pkt_t p;
    p.cable_header = hdr;
    p.status_byte  = st;
    p.data_one     = d1;
    p.data_two     = d2;
    p.last         = last;
    packets_due.push_back(p);
  endfunction

  function automatic void encode_timecode(mtc_cmd_t cmd, logic [31:0] ms);
    logic [31:0] fps;
    logic [31:0] product;
    logic [31:0] total;
    logic [31:0] ff;
    logic [31:0] ss;
    logic [31:0] mm;
    logic [31:0] hh;
    logic [3:0]  nib;
    int          k;
    fps     = FRAMES_PER_SECOND;
    // product wraps to 32 bits before the divide
    product = ms * fps;
    total   = product / 32'd1000;
    ff      = total % fps;
    ss      = (total / fps) % 32'd60;
    mm      = (total / (fps * 32'd60)) % 32'd60;
    hh      = (total / (fps * 32'd3600)) % 32'd24;
    case (cmd)
      CMD_QUARTER: begin
        for (k = 0; k < 8; k++) begin
          case (k)
            0:       nib = ff[3:0];
            1:       nib = {3'b000, ff[4]};
            2:       nib = ss[3:0];
            3:       nib = {2'b00, ss[5:4]};
            4:       nib = mm[3:0];
            5:       nib = {2'b00, mm[5:4]};
            6:       nib = hh[3:0];
            default: nib = {1'b0, RATE_CODE, hh[4]};
          endcase
          queue_packet(CIN_QUARTER, ST_QUARTER, {1'b0, 3'(k), nib}, 8'h00, k == 7);
        end
      end
      CMD_FULL: begin
        queue_packet(CIN_SYSEX, ST_SYSEX, ST_UNIV_RT, ST_UNIV_RT, 1'b0);
        queue_packet(CIN_SYSEX, SX_MTC, SX_FULL, {1'b0, RATE_CODE, hh[4:0]}, 1'b0);
        queue_packet(CIN_SYSEX, mm[7:0], ss[7:0], ff[7:0], 1'b0);
        queue_packet(CIN_SYSEX_E1, ST_EOX, 8'h00, 8'h00, 1'b1);
      end
      CMD_START: begin
        queue_packet(CIN_REALTIME, ST_START, 8'h00, 8'h00, 1'b1);
      end
      default: begin
        queue_packet(CIN_REALTIME, ST_STOP, 8'h00, 8'h00, 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        encode_timecode(mtc_cmd_t'(in_command), in_position_ms);
      end
      if (out_valid && !out_stall) begin
        got = {out_cable_header, out_status_byte, out_data_one, out_data_two, out_last};
        if (packets_due.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: packet with nothing pending: hdr %h st %h d1 %h d2 %h last %b",
                     $realtime, got.cable_header, got.status_byte, got.data_one,
                     got.data_two, got.last);
          end
        end else begin
          want = packets_due.pop_front();
          checked++;
          if (want != got) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: packet mismatch: hdr %h/%h st %h/%h d1 %h/%h d2 %h/%h last %b/%b",
                       $realtime, want.cable_header, got.cable_header, want.status_byte,
                       got.status_byte, want.data_one, got.data_one, want.data_two,
                       got.data_two, want.last, got.last);
            end
          end
        end
      end
    end
    mismatches      <= fails;
    packets_waiting <= packets_due.size();
    packets_checked <= checked;
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import mtc_enc_pkg::*;

  localparam int unsigned FPS = MTC_FPS_DEFAULT;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [31:0] in_position_ms;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_cable_header;
  logic [7:0]  out_status_byte;
  logic [7:0]  out_data_one;
  logic [7:0]  out_data_two;
  logic        out_last;

  int mismatches;
  int packets_waiting;
  int packets_checked;
  int items_by_cmd[4];
  bit steady_send;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  midi_timecode_packet_encoder_core #(
    .FRAMES_PER_SECOND(FPS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_position_ms  (in_position_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cable_header(out_cable_header),
    .out_status_byte (out_status_byte),
    .out_data_one    (out_data_one),
    .out_data_two    (out_data_two),
    .out_last        (out_last)
  );

  mtc_packet_checker #(
    .FRAMES_PER_SECOND(FPS)
  ) chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_position_ms  (in_position_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cable_header(out_cable_header),
    .out_status_byte (out_status_byte),
    .out_data_one    (out_data_one),
    .out_data_two    (out_data_two),
    .out_last        (out_last),
    .mismatches      (mismatches),
    .packets_waiting (packets_waiting),
    .packets_checked (packets_checked)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_position();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1:    return $urandom();
      7:       return $urandom_range(86_400_000, 143_165_576);
      8:       return $urandom_range(143_165_577, 32'hFFFF_FFFF);
      9:       return $urandom_range(0, 2000);
      default: return $urandom_range(0, 86_399_999);
    endcase
  endfunction

  task automatic send_item(mtc_cmd_t cmd, logic [31:0] ms);
    int gap;
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_position_ms <= ms;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    items_by_cmd[cmd]++;
    gap = steady_send ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid       <= 1'b0;
      in_position_ms <= $urandom();
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: random hold-offs, free runs, and one long hold to back up the pipe
  initial begin
    int hold_left;
    int run_left;
    int cycle;
    hold_left = 0;
    run_left  = 0;
    cycle     = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle == 600) begin
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (run_left > 0) begin
        out_stall <= 1'b0;
        run_left--;
      end else begin
        hold_left = pick_gap();
        run_left  = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
        out_stall <= (hold_left != 0);
        if (hold_left != 0) begin
          hold_left--;
        end
      end
    end
  end

  initial begin
    int i;
    in_valid       <= 1'b0;
    in_command     <= CMD_QUARTER;
    in_position_ms <= '0;
    rst_n          <= 1'b0;
    steady_send    = 1'b0;
    for (i = 0; i < 4; i++) begin
      items_by_cmd[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_item(CMD_QUARTER, 32'd0);
    send_item(CMD_FULL, 32'd0);
    send_item(CMD_START, 32'd0);
    send_item(CMD_STOP, 32'hFFFF_FFFF);
    send_item(CMD_START, 32'hFFFF_FFFF);
    send_item(CMD_STOP, 32'd0);
    send_item(CMD_QUARTER, 32'hFFFF_FFFF);
    send_item(CMD_FULL, 32'hFFFF_FFFF);
    // last frame of the day, then the day wrap
    send_item(CMD_QUARTER, 32'd86_399_999);
    send_item(CMD_FULL, 32'd86_399_999);
    send_item(CMD_QUARTER, 32'd86_400_000);
    send_item(CMD_FULL, 32'd86_400_033);
    // either side of the 32-bit product wrap
    send_item(CMD_QUARTER, 32'd143_165_576);
    send_item(CMD_FULL, 32'd143_165_577);
    send_item(CMD_QUARTER, 32'd143_165_577);
    send_item(CMD_QUARTER, 32'd59_027_967);
    send_item(CMD_FULL, 32'd59_027_967);
    send_item(CMD_QUARTER, 32'd566);

    for (i = 0; i < 212; i++) begin
      steady_send = ((i / 40) % 3 == 1);
      send_item(mtc_cmd_t'($urandom_range(0, 3)), pick_position());
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (packets_waiting != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    $display("covered %0d quarter-frame, %0d full-frame, %0d start and %0d stop items",
             items_by_cmd[CMD_QUARTER], items_by_cmd[CMD_FULL], items_by_cmd[CMD_START],
             items_by_cmd[CMD_STOP]);
    $display("%0d packets compared, with random and one long result-side hold-off",
             packets_checked);
    if (mismatches == 0 && packets_waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
